// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/cdeq_pkg.sv -----
// Types, constants and widths shared by the deque modules.
package cdeq_pkg;

    localparam int DEF_CAPACITY = 8;

    localparam int DATA_W     = 32;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 4;
    localparam int OUT_DATA_W = 40;   // pop_value + occupancy, padded to bytes

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic exec;     // apply the accepted transaction this cycle
    } t_dp_cmd;

endpackage

// ----- rtl/core/cdeq_ctrl.sv -----
// Handshake controller: accepts a transaction, then holds the result until taken.
module cdeq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output cdeq_pkg::t_dp_cmd o_cmd
);
    import cdeq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.exec = i_in_valid;
            end
            ST_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/cdeq_dp.sv -----
// Deque datapath: circular store, front/back indices, count and result registers.
module cdeq_dp #(
    parameter int CAPACITY = cdeq_pkg::DEF_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdeq_pkg::t_dp_cmd             i_cmd,
    input  cdeq_pkg::t_mode               i_mode,
    input  logic [cdeq_pkg::DATA_W-1:0]   i_push_value,
    output cdeq_pkg::t_status             o_status,
    output logic [cdeq_pkg::DATA_W-1:0]   o_pop_value,
    output logic [cdeq_pkg::OCC_W-1:0]    o_occupancy
);
    import cdeq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    logic [DATA_W-1:0] r_mem [CAPACITY];

    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back,  n_back;
    logic [CNT_W-1:0] r_count, n_count;

    t_status           r_status, n_status;
    logic              r_pop_ok, n_pop_ok;
    logic [DATA_W-1:0] r_rd_data;

    logic [IDX_W-1:0] front_up, front_dn, back_up, back_dn;
    logic [IDX_W-1:0] addr;
    logic             wr_en;
    logic             full, empty;
    logic [CNT_W+OCC_W-1:0] count_ext;

    assign front_up = (r_front == LAST_IDX) ? '0 : r_front + 1'b1;
    assign front_dn = (r_front == '0) ? LAST_IDX : r_front - 1'b1;
    assign back_up  = (r_back == LAST_IDX) ? '0 : r_back + 1'b1;
    assign back_dn  = (r_back == '0) ? LAST_IDX : r_back - 1'b1;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = STAT_DONE;
        n_pop_ok = 1'b0;
        addr     = r_back;
        wr_en    = 1'b0;
        case (i_mode)
            MODE_PUSH_BACK: begin
                addr = r_back;
                if (full) begin
                    n_status = STAT_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_back  = back_up;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_PUSH_FRONT: begin
                addr = front_dn;
                if (full) begin
                    n_status = STAT_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_front = front_dn;
                    n_count = r_count + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                addr = r_front;
                if (empty) begin
                    n_status = STAT_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    n_front  = front_up;
                    n_count  = r_count - 1'b1;
                end
            end
            MODE_POP_BACK: begin
                addr = back_dn;
                if (empty) begin
                    n_status = STAT_UNDERFLOW;
                end else begin
                    n_pop_ok = 1'b1;
                    n_back   = back_dn;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                n_status = STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[addr] <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[addr];
        end
    end

    assign count_ext   = {{OCC_W{1'b0}}, r_count};
    assign o_status    = r_status;
    assign o_pop_value = r_pop_ok ? r_rd_data : '0;
    assign o_occupancy = count_ext[OCC_W-1:0];

endmodule

// ----- rtl/core/circular_double_ended_queue.sv -----
// Top level of the circular double-ended queue.
//
// Usage:
//   Input stream (s_axis_*): one transaction per operation. s_axis_tuser carries
//   the mode (push back, push front, pop front, pop back), s_axis_tdata the
//   32-bit value stored by a push (ignored on pops).
//   Output stream (m_axis_*): exactly one transaction per input transaction.
//   m_axis_tuser carries the status (done, overflow, underflow); m_axis_tdata
//   carries the popped value (zero unless a pop succeeded) and the occupancy
//   after the operation (held count, low 4 bits).
// Latency: the result is valid the cycle after the input is accepted.
// Flow: one transaction is in flight at a time, and s_axis_tready is low
//   from acceptance until the result is taken.
// Reset (i_rst_n low, synchronous): the queue empties, both indices return to
//   slot 0 and any pending result is dropped. Store contents are not cleared.
// Receiver stall: with m_axis_tready low the result and its payload hold, and
//   no new operation is taken until the result is delivered.
module circular_double_ended_queue #(
    parameter int CAPACITY = cdeq_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cdeq_pkg::DATA_W-1:0]       s_axis_tdata,  // [31:0] push_value
    input  logic [cdeq_pkg::MODE_W-1:0]       s_axis_tuser,  // [1:0] mode
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cdeq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [31:0] pop_value,
                                                             // [35:32] occupancy,
                                                             // [39:36] zero
    output logic [cdeq_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);
    import cdeq_pkg::*;

    t_dp_cmd           cmd;
    t_status           status;
    logic [DATA_W-1:0] pop_value;
    logic [OCC_W-1:0]  occupancy;

    // controller: transaction sequencing only
    cdeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // datapath: store, indices, count and registered result
    cdeq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (t_mode'(s_axis_tuser)),
        .i_push_value (s_axis_tdata),
        .o_status     (status),
        .o_pop_value  (pop_value),
        .o_occupancy  (occupancy)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - DATA_W - OCC_W){1'b0}}, occupancy, pop_value};
    assign m_axis_tuser = status;

endmodule

// ----- rtl/core/cdeq_checker.sv -----
// Port-level checker for the deque, bound to the top level.
`include "assert_macros.svh"

module cdeq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cdeq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [cdeq_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import cdeq_pkg::*;

    logic out_stall;
    logic in_accept;
    logic out_fail;
    logic status_known;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign out_fail     = m_axis_tvalid && (m_axis_tuser != STAT_DONE);
    assign status_known = (m_axis_tuser == STAT_DONE) ||
                          (m_axis_tuser == STAT_OVERFLOW) ||
                          (m_axis_tuser == STAT_UNDERFLOW);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))

    // one operation in flight: no input taken while a result waits
    `ASSERT_NOW(a_no_accept_pending, m_axis_tvalid, !s_axis_tready)

    // every accepted operation yields a result next cycle
    `ASSERT_NEXT(a_result_follows, in_accept, m_axis_tvalid)

    // failed operations return zero data
    `ASSERT_NOW(a_fail_zero, out_fail, m_axis_tdata[DATA_W-1:0] == '0)

    // only defined status codes appear
    `ASSERT_NOW(a_status_code, m_axis_tvalid, status_known)

endmodule

bind circular_double_ended_queue cdeq_checker u_cdeq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
